@@ rtl/core/atqi_pkg.sv @@
package atqi_pkg;

    localparam int NUM_SEGMENTS_DEF = 10;
    localparam int ADC_BITS_DEF     = 12;

    // port field widths
    localparam int CODE_FIELD_W  = 12;
    localparam int INDEX_FIELD_W = 4;
    localparam int IN_TDATA_W    = 32;
    localparam int TEMP_W        = 24;
    localparam int STATUS_W      = 2;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 17;
    localparam int STEP_W        = 16;
    localparam int TEMP_CFG_W    = 17;

    localparam int TEMP_MAX = 8388607;
    localparam int TEMP_MIN = -8388608;

    localparam logic signed [TEMP_CFG_W-1:0] START_TEMP_RST = 17'sd0;
    localparam logic [STEP_W-1:0]            STEP_TEMP_RST  = 16'd2560;
    localparam logic signed [TEMP_CFG_W-1:0] END_TEMP_RST   = 17'sd25600;

    localparam logic ACT_CONVERT = 1'b0;
    localparam logic ACT_LOAD    = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_TEMP = 2'd0,
        CFG_STEP_TEMP  = 2'd1,
        CFG_END_TEMP   = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_IN_RANGE  = 2'd0,
        ST_BELOW     = 2'd1,
        ST_ABOVE     = 2'd2,
        ST_LOAD_ACK  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOW,
        S_HIGH,
        S_SRCH,
        S_RDA,
        S_RDB,
        S_LSET,
        S_LRUN,
        S_LACC,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_RND,
        MD_DIV,
        MD_FIN
    } t_md_phase;

    typedef struct packed {
        logic start;
        logic wide;
    } t_md_ctl;

    localparam int RESET_NODE_CNT = 11;
    localparam logic [15:0] RESET_NODES [RESET_NODE_CNT] = '{
        16'd86, 16'd376, 16'd687, 16'd1021, 16'd1379, 16'd1760,
        16'd2164, 16'd2592, 16'd3043, 16'd3515, 16'd4008
    };

    // entries past the calibrated set repeat the last node
    function automatic logic [15:0] node_reset_val(input int k);
        return RESET_NODES[(k < RESET_NODE_CNT) ? k : RESET_NODE_CNT - 1];
    endfunction

endpackage

@@ rtl/core/adc_temperature_quadratic_interp_unit.sv @@
// Channel   Dir  Accept               Payload
// s_*       in   i_s_tvalid&tready    tdata: adc_code, node_index, node_code; tuser: action
// m_*       out  o_m_tvalid&tready    tdata: temperature; tuser: range_status
// cfg_*     in   i_cfg_we             register index, write data
//
// For a conversion inside the table, the shared shift-add / restoring-divide unit
// runs once per line, one bit per cycle, for three lines. One request at a time;
// ready only when idle. Synchronous active-low reset restores the config registers
// and the node table. The finished result sits in the output register while the next
// request is taken.
module adc_temperature_quadratic_interp_unit #(
    parameter int NUM_SEGMENTS = atqi_pkg::NUM_SEGMENTS_DEF,
    parameter int ADC_BITS     = atqi_pkg::ADC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [11:0] adc_code, [15:12] node_index, [27:16] node_code, [31:28] zero
    input  logic [atqi_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // [0] action
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [23:0] temperature
    output logic [atqi_pkg::TEMP_W-1:0]        o_m_tdata,
    // [1:0] range_status
    output logic [atqi_pkg::STATUS_W-1:0]      o_m_tuser,
    input  logic                               i_cfg_we,
    input  logic [atqi_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [atqi_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import atqi_pkg::*;

    localparam int NODES = NUM_SEGMENTS + 1;
    localparam int AW    = $clog2(NODES);
    localparam int CW    = ADC_BITS;
    localparam int MW    = CW + 18;
    localparam int NW    = 2 * CW + 19;
    localparam int YW    = 2 * CW + 21;
    localparam int EXTW  = (CW > CODE_FIELD_W) ? CW : CODE_FIELD_W;
    localparam int IW    = (AW > INDEX_FIELD_W) ? AW : INDEX_FIELD_W;

    localparam logic [1:0] LINE_01  = 2'd0;
    localparam logic [1:0] LINE_02  = 2'd1;
    localparam logic [1:0] LINE_012 = 2'd2;

    localparam logic signed [YW-1:0] Y_MAX = YW'(TEMP_MAX);
    localparam logic signed [YW-1:0] Y_MIN = YW'(TEMP_MIN);

    function automatic logic [CW-1:0] reset_code(input int k);
        logic [15:0] v;
        v = node_reset_val(k);
        return v[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] p, input logic [CW-1:0] q);
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    function automatic logic [TEMP_W-1:0] sat24(input logic signed [YW-1:0] y);
        if (y > Y_MAX) begin
            return TEMP_W'(TEMP_MAX);
        end else if (y < Y_MIN) begin
            return TEMP_W'(TEMP_MIN);
        end
        return y[TEMP_W-1:0];
    endfunction

    t_state                    r_state, n_state;
    logic signed [TEMP_CFG_W-1:0] r_start, r_end;
    logic [STEP_W-1:0]         r_step;
    logic [CW-1:0]             r_node [NODES];

    logic [CW-1:0]             r_x, n_x, r_a, n_a, r_b, n_b, r_c, n_c;
    logic [AW-1:0]             r_addr, n_addr, r_seg, n_seg;
    logic [1:0]                r_line, n_line;
    logic                      r_neg, n_neg, r_dz, n_dz;
    logic signed [YW-1:0]      r_y0, n_y0, r_l01, n_l01, r_l02, n_l02, r_term, n_term;
    logic [TEMP_W-1:0]         r_res_temp, n_res_temp;
    t_status                   r_res_status, n_res_status;

    logic                      r_m_tvalid;
    logic [TEMP_W-1:0]         r_m_tdata;
    t_status                   r_m_tuser;

    logic [EXTW-1:0]           code_ext, ncode_ext;
    logic [IW-1:0]             idx_ext;
    logic                      idx_ok;
    logic                      node_we;
    logic [CW-1:0]             rd;
    logic [AW-1:0]             seg_m1;
    logic [STEP_W+AW-1:0]      step_prod;
    logic signed [YW-1:0]      ldiff, ldiff_abs, lsum;
    logic                      out_free, out_load;

    t_md_ctl                   md_ctl;
    logic [MW-1:0]             md_mcand;
    logic [CW-1:0]             md_mplier, md_divisor;
    logic                      md_done;
    logic [NW-1:0]             md_quot;

    atqi_muldiv #(
        .ADC_BITS (ADC_BITS)
    ) u_muldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (md_ctl),
        .i_mcand   (md_mcand),
        .i_mplier  (md_mplier),
        .i_divisor (md_divisor),
        .o_done    (md_done),
        .o_quot    (md_quot)
    );

    assign code_ext  = EXTW'(i_s_tdata[11:0]);
    assign ncode_ext = EXTW'(i_s_tdata[27:16]);
    assign idx_ext   = IW'(i_s_tdata[15:12]);
    assign idx_ok    = (idx_ext <= IW'(NUM_SEGMENTS));

    assign rd        = r_node[r_addr];
    assign seg_m1    = r_seg - 1'b1;
    assign step_prod = (STEP_W + AW)'(r_step) * (STEP_W + AW)'(seg_m1);

    assign ldiff     = r_l02 - r_l01;
    assign ldiff_abs = ldiff[YW-1] ? -ldiff : ldiff;
    assign lsum      = ((r_line == LINE_012) ? r_l01 : r_y0) + r_term;

    assign out_free  = !r_m_tvalid || i_m_tready;
    assign out_load  = (r_state == S_DONE) && out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_TEMP_RST;
            r_step  <= STEP_TEMP_RST;
            r_end   <= END_TEMP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_START_TEMP: r_start <= $signed(i_cfg_wdata);
                CFG_STEP_TEMP:  r_step  <= i_cfg_wdata[STEP_W-1:0];
                CFG_END_TEMP:   r_end   <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // node table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NODES; k++) begin
                r_node[k] <= reset_code(k);
            end
        end else if (node_we) begin
            r_node[idx_ext[AW-1:0]] <= ncode_ext[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_a          <= n_a;
        r_b          <= n_b;
        r_c          <= n_c;
        r_addr       <= n_addr;
        r_seg        <= n_seg;
        r_line       <= n_line;
        r_neg        <= n_neg;
        r_dz         <= n_dz;
        r_y0         <= n_y0;
        r_l01        <= n_l01;
        r_l02        <= n_l02;
        r_term       <= n_term;
        r_res_temp   <= n_res_temp;
        r_res_status <= n_res_status;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= r_res_temp;
            r_m_tuser <= r_res_status;
        end
    end

    // operands for the line being evaluated
    always_comb begin
        md_ctl.wide = 1'b0;
        case (r_line)
            LINE_01: begin
                md_mcand   = MW'(r_step);
                md_mplier  = absdiff(r_x, r_a);
                md_divisor = absdiff(r_b, r_a);
            end
            LINE_02: begin
                md_mcand   = MW'({r_step, 1'b0});
                md_mplier  = absdiff(r_x, r_a);
                md_divisor = absdiff(r_c, r_a);
            end
            default: begin
                md_mcand    = ldiff_abs[MW-1:0];
                md_mplier   = absdiff(r_x, r_b);
                md_divisor  = absdiff(r_c, r_b);
                md_ctl.wide = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_a          = r_a;
        n_b          = r_b;
        n_c          = r_c;
        n_addr       = r_addr;
        n_seg        = r_seg;
        n_line       = r_line;
        n_neg        = r_neg;
        n_dz         = r_dz;
        n_y0         = r_y0;
        n_l01        = r_l01;
        n_l02        = r_l02;
        n_term       = r_term;
        n_res_temp   = r_res_temp;
        n_res_status = r_res_status;
        node_we      = 1'b0;
        md_ctl.start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (i_s_tuser)
                        ACT_LOAD: begin
                            node_we      = idx_ok;
                            n_res_temp   = '0;
                            n_res_status = ST_LOAD_ACK;
                            n_state      = S_DONE;
                        end
                        ACT_CONVERT: begin
                            n_x     = code_ext[CW-1:0];
                            n_addr  = '0;
                            n_state = S_LOW;
                        end
                    endcase
                end
            end
            S_LOW: begin
                if (r_x < rd) begin
                    n_res_temp   = TEMP_W'(r_start);
                    n_res_status = ST_BELOW;
                    n_state      = S_DONE;
                end else begin
                    n_addr  = AW'(NUM_SEGMENTS);
                    n_state = S_HIGH;
                end
            end
            S_HIGH: begin
                if (r_x >= rd) begin
                    n_res_temp   = TEMP_W'(r_end);
                    n_res_status = ST_ABOVE;
                    n_state      = S_DONE;
                end else begin
                    n_seg   = AW'(1);
                    n_addr  = AW'(2);
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // rd is node[seg+1]; the last segment is taken if nothing bounds x
                if (r_x < rd || r_seg == AW'(NUM_SEGMENTS - 1)) begin
                    n_c     = rd;
                    n_addr  = seg_m1;
                    n_state = S_RDA;
                end else begin
                    n_seg  = r_seg + 1'b1;
                    n_addr = r_addr + 1'b1;
                end
            end
            S_RDA: begin
                n_a     = rd;
                n_addr  = r_seg;
                n_y0    = YW'(r_start) + YW'(step_prod);
                n_state = S_RDB;
            end
            S_RDB: begin
                n_b     = rd;
                n_line  = LINE_01;
                n_state = S_LSET;
            end
            S_LSET: begin
                md_ctl.start = 1'b1;
                case (r_line)
                    LINE_01: begin
                        n_neg = (r_x < r_a) ^ (r_b < r_a);
                        n_dz  = (r_b == r_a);
                    end
                    LINE_02: begin
                        n_neg = (r_x < r_a) ^ (r_c < r_a);
                        n_dz  = (r_c == r_a);
                    end
                    default: begin
                        n_neg = ldiff[YW-1] ^ (r_x < r_b) ^ (r_c < r_b);
                        n_dz  = (r_c == r_b);
                    end
                endcase
                n_state = S_LRUN;
            end
            S_LRUN: begin
                if (md_done) begin
                    if (r_dz) begin
                        n_term = '0;
                    end else if (r_neg) begin
                        n_term = -YW'(md_quot);
                    end else begin
                        n_term = YW'(md_quot);
                    end
                    n_state = S_LACC;
                end
            end
            S_LACC: begin
                case (r_line)
                    LINE_01: begin
                        n_l01   = lsum;
                        n_line  = LINE_02;
                        n_state = S_LSET;
                    end
                    LINE_02: begin
                        n_l02   = lsum;
                        n_line  = LINE_012;
                        n_state = S_LSET;
                    end
                    default: begin
                        n_res_temp   = sat24(lsum);
                        n_res_status = ST_IN_RANGE;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_done |-> (r_state == S_LRUN))
        else $error("arith unit finished outside line wait");

    a_load_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == ACT_LOAD)
        |=> (r_state == S_DONE && r_res_status == ST_LOAD_ACK))
        else $error("load request not acknowledged");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_seg >= AW'(1) && r_seg <= AW'(NUM_SEGMENTS - 1)))
        else $error("segment search out of range");

endmodule

@@ rtl/core/atqi_muldiv.sv @@
module atqi_muldiv #(
    parameter int ADC_BITS = atqi_pkg::ADC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  atqi_pkg::t_md_ctl       i_ctl,
    input  logic [ADC_BITS+17:0]    i_mcand,
    input  logic [ADC_BITS-1:0]     i_mplier,
    input  logic [ADC_BITS-1:0]     i_divisor,
    output logic                    o_done,
    output logic [2*ADC_BITS+18:0]  o_quot
);
    import atqi_pkg::*;

    localparam int CW   = ADC_BITS;
    localparam int NW   = 2 * CW + 19;   // full product + rounding
    localparam int KN   = CW + 18;       // numerator width of the first two lines
    localparam int CNTW = $clog2(NW + 1);

    t_md_phase        r_ph, n_ph;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic [NW-1:0]    r_acc, n_acc;
    logic [NW-1:0]    r_mc, n_mc;
    logic [CW-1:0]    r_mq, n_mq;
    logic [CW-1:0]    r_dv, n_dv;
    logic [CW-1:0]    r_rem, n_rem;
    logic             r_wide, n_wide;

    logic [NW-1:0]    rnd_sum;
    logic [CW:0]      trial;
    logic             trial_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= MD_IDLE;
        end else begin
            r_ph <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_mc   <= n_mc;
        r_mq   <= n_mq;
        r_dv   <= n_dv;
        r_rem  <= n_rem;
        r_wide <= n_wide;
    end

    assign rnd_sum  = r_acc + NW'(r_dv >> 1);
    assign trial    = {r_rem, r_acc[NW-1]};
    assign trial_ge = (trial >= {1'b0, r_dv});

    always_comb begin
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mq   = r_mq;
        n_dv   = r_dv;
        n_rem  = r_rem;
        n_wide = r_wide;
        o_done = 1'b0;
        unique case (r_ph)
            MD_IDLE: begin
                if (i_ctl.start) begin
                    n_acc  = '0;
                    n_mc   = NW'(i_mcand);
                    n_mq   = i_mplier;
                    n_dv   = i_divisor;
                    n_wide = i_ctl.wide;
                    n_cnt  = CNTW'(CW);
                    n_ph   = MD_MUL;
                end
            end
            MD_MUL: begin
                // shift-add, one multiplier bit per cycle
                if (r_mq[0]) begin
                    n_acc = r_acc + r_mc;
                end
                n_mc  = r_mc << 1;
                n_mq  = r_mq >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    n_ph = MD_RND;
                end
            end
            MD_RND: begin
                // add half divisor; narrow numerators are left-aligned
                n_acc = r_wide ? rnd_sum : (rnd_sum << (NW - KN));
                n_rem = '0;
                n_cnt = r_wide ? CNTW'(NW) : CNTW'(KN);
                n_ph  = MD_DIV;
            end
            MD_DIV: begin
                // restoring division, quotient shifts in at the bottom
                n_rem = trial_ge ? CW'(trial - {1'b0, r_dv}) : trial[CW-1:0];
                n_acc = {r_acc[NW-2:0], trial_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    n_ph = MD_FIN;
                end
            end
            MD_FIN: begin
                o_done = 1'b1;
                n_ph   = MD_IDLE;
            end
            default: begin
                n_ph = MD_IDLE;
            end
        endcase
    end

    assign o_quot = r_acc;

endmodule

@@ tb/sv/adc_temperature_quadratic_interp_unit_test.sv @@
module adc_temperature_quadratic_interp_unit_test;
    import atqi_pkg::*;

    localparam int NUM_SEG  = NUM_SEGMENTS_DEF;
    localparam int NODE_CNT = NUM_SEG + 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int CAL_CODES [11] = '{86, 376, 687, 1021, 1379, 1760, 2164, 2592, 3043, 3515, 4008};

    typedef struct packed {
        logic                     action;
        logic [CODE_FIELD_W-1:0]  adc_code;
        logic [INDEX_FIELD_W-1:0] node_index;
        logic [CODE_FIELD_W-1:0]  node_code;
    } sample_req_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        t_status           status;
    } temp_result_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata = '0;
    logic                    i_s_tuser = 1'b0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [TEMP_W-1:0]       o_m_tdata;
    logic [STATUS_W-1:0]     o_m_tuser;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;

    adc_temperature_quadratic_interp_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    // predictor state, tracks the block as requests are accepted
    logic [CODE_FIELD_W-1:0]       node_tab [NODE_CNT];
    logic signed [TEMP_CFG_W-1:0]  cfg_start;
    logic [STEP_W-1:0]             cfg_step;
    logic signed [TEMP_CFG_W-1:0]  cfg_end;

    sample_req_t  pending_reqs [$];
    temp_result_t expected_results [$];
    int           err_cnt = 0;
    bit           req_taken = 1'b0;
    bit           no_idle = 1'b0;

    // round to nearest, ties away from zero; zero divisor gives zero
    function automatic longint div_nearest(input longint n, input longint d);
        longint un, ud, q;
        if (d == 0)
            return 0;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint line_val(input longint x, input longint x0, input longint y0,
                                        input longint x1, input longint y1);
        return y0 + div_nearest((y1 - y0) * (x - x0), x1 - x0);
    endfunction

    function automatic temp_result_t predict_temperature(input logic [CODE_FIELD_W-1:0] code);
        temp_result_t res;
        longint x, a, b, c, s, y0, l01, l02, v;
        int seg;
        x = longint'(code);
        res.status = ST_IN_RANGE;
        if (x < longint'(node_tab[0])) begin
            v = longint'(cfg_start);
            res.status = ST_BELOW;
        end else if (x >= longint'(node_tab[NUM_SEG])) begin
            v = longint'(cfg_end);
            res.status = ST_ABOVE;
        end else begin
            seg = 1;
            while (seg < NUM_SEG - 1 && x >= longint'(node_tab[seg+1]))
                seg++;
            a = longint'(node_tab[seg-1]);
            b = longint'(node_tab[seg]);
            c = longint'(node_tab[seg+1]);
            s = longint'(cfg_step);
            y0 = longint'(cfg_start) + s * (seg - 1);
            l01 = line_val(x, a, y0, b, y0 + s);
            l02 = line_val(x, a, y0, c, y0 + 2 * s);
            v = line_val(x, b, l01, c, l02);
        end
        if (v > TEMP_MAX)
            v = TEMP_MAX;
        if (v < TEMP_MIN)
            v = TEMP_MIN;
        res.temp = v[TEMP_W-1:0];
        return res;
    endfunction

    // scoreboard: output check, config tracking, prediction on accepted requests
    sample_req_t  acc_req;
    temp_result_t exp_res;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NODE_CNT; k++)
                node_tab[k] = CAL_CODES[(k < 11) ? k : 10];
            cfg_start = START_TEMP_RST;
            cfg_step  = STEP_TEMP_RST;
            cfg_end   = END_TEMP_RST;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result temp %h status %0d",
                             $time, o_m_tdata, o_m_tuser);
                    err_cnt++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_m_tdata !== exp_res.temp) begin
                        $display("%0t: temperature mismatch, expected %h actual %h",
                                 $time, exp_res.temp, o_m_tdata);
                        err_cnt++;
                    end
                    if (o_m_tuser !== exp_res.status) begin
                        $display("%0t: range status mismatch, expected %0d actual %0d",
                                 $time, exp_res.status, o_m_tuser);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_START_TEMP: cfg_start = i_cfg_wdata;
                    CFG_STEP_TEMP:  cfg_step  = i_cfg_wdata[STEP_W-1:0];
                    CFG_END_TEMP:   cfg_end   = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                req_taken = 1'b1;
                acc_req.action     = i_s_tuser;
                acc_req.adc_code   = i_s_tdata[11:0];
                acc_req.node_index = i_s_tdata[15:12];
                acc_req.node_code  = i_s_tdata[27:16];
                if (acc_req.action == ACT_LOAD) begin
                    if (acc_req.node_index < NODE_CNT)
                        node_tab[acc_req.node_index] = acc_req.node_code;
                    expected_results.push_back('{temp: '0, status: ST_LOAD_ACK});
                end else begin
                    expected_results.push_back(predict_temperature(acc_req.adc_code));
                end
            end
        end
    end

    // request driver: bursts of random length, random gaps
    sample_req_t drv_req;
    logic        drv_valid;
    int          burst_left = 0;
    int          gap_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 7);
        if (r < 3)
            return 0;
        if (r < 6)
            return $urandom_range(1, 6);
        if (r < 7)
            return $urandom_range(7, 40);
        return $urandom_range(41, 150);
    endfunction

    always @(negedge i_clk) begin
        drv_valid = i_s_tvalid;
        if (!i_rst_n) begin
            drv_valid = 1'b0;
        end else if (!(i_s_tvalid && !req_taken)) begin
            drv_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                drv_req = pending_reqs.pop_front();
                i_s_tdata <= {4'b0, drv_req.node_code, drv_req.node_index, drv_req.adc_code};
                i_s_tuser <= drv_req.action;
                drv_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = no_idle ? 0 : pick_gap();
                end
            end
        end
        req_taken = 1'b0;
        i_s_tvalid <= drv_valid;
    end

    // result receiver: ready runs and stalls of random length
    int   rx_hold_left = 0;
    logic rx_ready = 1'b1;

    always @(negedge i_clk) begin
        int r;
        if (rx_hold_left == 0) begin
            r = $urandom_range(0, 9);
            if (no_idle || r < 5) begin
                rx_ready = 1'b1;
                rx_hold_left = $urandom_range(1, 80);
            end else begin
                rx_ready = 1'b0;
                if (r < 8)
                    rx_hold_left = $urandom_range(1, 10);
                else if (r < 9)
                    rx_hold_left = $urandom_range(11, 40);
                else
                    rx_hold_left = $urandom_range(41, 150);
            end
        end
        rx_hold_left--;
        i_m_tready <= rx_ready;
    end

    // stimulus planning, with a shadow of the node table as loaded so far
    int plan_nodes [NODE_CNT];

    task automatic queue_convert(input int code);
        sample_req_t r;
        r = '0;
        r.action = ACT_CONVERT;
        r.adc_code = code;
        r.node_index = $urandom_range(0, 15);
        r.node_code = $urandom_range(0, 4095);
        pending_reqs.push_back(r);
    endtask

    task automatic queue_load(input int idx, input int code);
        sample_req_t r;
        r.action = ACT_LOAD;
        r.adc_code = $urandom_range(0, 4095);
        r.node_index = idx;
        r.node_code = code;
        if (idx < NODE_CNT)
            plan_nodes[idx] = code;
        pending_reqs.push_back(r);
    endtask

    function automatic int clamp_code(input int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    task automatic fill_table(input int kind);
        int v;
        v = (kind == 1) ? $urandom_range(0, 400) : $urandom_range(0, 3000);
        for (int k = 0; k < NODE_CNT; k++) begin
            case (kind)
                0: queue_load(k, clamp_code(CAL_CODES[k] + $urandom_range(0, 40) - 20));
                1: begin
                    queue_load(k, v);
                    v = clamp_code(v + $urandom_range(1, 420));
                end
                2: queue_load(k, $urandom_range(0, 4095));
                default: begin
                    // tight cluster then a far last node: huge extrapolation slopes
                    if (k == NUM_SEG)
                        queue_load(k, $urandom_range(v, 4095));
                    else
                        queue_load(k, v);
                    v = clamp_code(v + $urandom_range(0, 2));
                end
            endcase
        end
    endtask

    function automatic int pick_code();
        int r, lo, hi;
        r = $urandom_range(0, 9);
        lo = plan_nodes[0];
        hi = plan_nodes[NUM_SEG];
        if (r < 6 && hi > lo)
            return $urandom_range(lo, hi - 1);
        if (r < 8)
            return clamp_code(plan_nodes[$urandom_range(0, NUM_SEG)] + $urandom_range(0, 2) - 1);
        return $urandom_range(0, 4095);
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic program_regs(input logic [16:0] start_t, input logic [16:0] step_t,
                                input logic [16:0] top_t, input bit poke_unused);
        write_reg(CFG_START_TEMP, start_t);
        write_reg(CFG_STEP_TEMP, step_t);
        write_reg(CFG_END_TEMP, top_t);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, $urandom_range(0, 131071));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        for (int k = 0; k < NODE_CNT; k++)
            plan_nodes[k] = CAL_CODES[(k < 11) ? k : 10];
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass on reset registers and table
        queue_convert(0);
        queue_convert(85);
        queue_convert(86);
        queue_convert(686);
        queue_convert(687);
        queue_convert(2000);
        queue_convert(4007);
        queue_convert(4008);
        queue_convert(4095);
        queue_load(15, 4095);       // out of range index: ack, no write
        queue_load(11, 0);
        queue_convert(4008);
        queue_load(1, 86);          // first two nodes equal
        queue_convert(86);
        queue_convert(200);
        queue_load(2, 86);          // three equal nodes
        queue_convert(500);
        queue_load(0, 0);
        queue_load(10, 4095);
        queue_convert(4094);
        queue_convert(0);
        queue_load(0, 86);
        queue_load(1, 376);
        queue_load(2, 687);
        queue_load(10, 4008);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            repeat (8) @(negedge i_clk);
            no_idle = (ph == 1);
            case (ph)
                0: program_regs(17'h10000, 17'h0FFFF, 17'h0FFFF, 1'b0);
                1: program_regs(17'h0FFFF, 17'h1FFFF, 17'h10000, 1'b0);
                2: program_regs($urandom_range(0, 131071), 17'h10000,
                                $urandom_range(0, 131071), 1'b1);
                3: program_regs(17'h00000, 17'h00001, 17'h00000, 1'b0);
                default: program_regs($urandom_range(0, 131071), $urandom_range(0, 131071),
                                      $urandom_range(0, 131071), ph == 5);
            endcase
            fill_table(ph == 1 ? 3 : ph % 4);
            for (int n = 0; n < 165; n++) begin
                if ($urandom_range(0, 99) < 8)
                    queue_load($urandom_range(0, 15), $urandom_range(0, 4095));
                else
                    queue_convert(pick_code());
            end
            wait_drained();
        end

        repeat (200) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
